// ----- rtl/spsc_pkg.sv -----
package spsc_pkg;

  localparam int DIST_WIDTH_DEF  = 16;
  localparam int COORD_WIDTH_DEF = 48;

  localparam logic [2:0] STEP_SAT = 3'd5;
  localparam logic [2:0] STEP_FREE = 3'd2;

  typedef enum logic [1:0] {
    HEAD_UP    = 2'd0,
    HEAD_LEFT  = 2'd1,
    HEAD_DOWN  = 2'd2,
    HEAD_RIGHT = 2'd3
  } heading_t;

  typedef struct packed {
    logic crossed;
    logic path_end;
  } res_t;

endpackage

// ----- rtl/spsc_if.sv -----
interface spsc_seg_if #(
  parameter int DIST_WIDTH = spsc_pkg::DIST_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [DIST_WIDTH-1:0] distance;
  logic                  last;

  modport source (output valid, output distance, output last, input ready);
  modport sink (input valid, input distance, input last, output ready);
endinterface

interface spsc_res_if;
  logic valid;
  logic ready;
  logic crossed;
  logic path_end;

  modport source (output valid, output crossed, output path_end, input ready);
  modport sink (input valid, input crossed, input path_end, output ready);
endinterface

// ----- rtl/spiral_path_self_crossing_check.sv -----
// self-crossing check for a counter-clockwise path (up, left, down, right, ...)
// seg channel: one segment length per transfer, last marks the final segment
// res channel: one result per segment; crossed is sticky within a path and
//   path_end echoes last, so the result with path_end set is the final answer
// the result is registered in the output buffer after the segment transfer;
//   throughput is one segment per cycle while seg.ready is high, set by the
//   combinational update of position and limits from the state registers
// segments after a crossing leave the state alone and report crossed
// after the last segment all tracking state returns to zero for the next path
// stalls: a two-entry output buffer keeps seg.ready high while res.ready is low
//   and the skid entry is free; seg.ready drops only while both entries are full
// reset (rst, synchronous): clears the path state and empties the buffer
// coordinates saturate at the signed COORD_WIDTH range
module spiral_path_self_crossing_check #(
  parameter int DIST_WIDTH  = spsc_pkg::DIST_WIDTH_DEF,
  parameter int COORD_WIDTH = spsc_pkg::COORD_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst,
  spsc_seg_if.sink seg,
  spsc_res_if.source res
);

  localparam int CW = COORD_WIDTH;
  localparam int SW = ((COORD_WIDTH > DIST_WIDTH) ? COORD_WIDTH : (DIST_WIDTH + 1)) + 1;
  localparam logic signed [SW-1:0] CMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  // limits kept relative to the heading: entry k belongs to heading + k
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] lim [4];
  logic signed [CW-1:0] elim [4];
  logic                 shrinking;
  logic [2:0]           step_count;
  spsc_pkg::heading_t   heading;
  logic                 crossed_seen;

  logic signed [CW-1:0] pos_x_next;
  logic signed [CW-1:0] pos_y_next;
  logic signed [CW-1:0] lim_upd [4];
  logic signed [CW-1:0] elim_upd [4];
  logic                 shrinking_next;
  logic                 crossed_next;

  logic                 accept;
  logic                 buf_ready;
  logic                 outward_pos;
  logic signed [SW-1:0] pos_w;
  logic signed [SW-1:0] dist_w;
  logic signed [SW-1:0] sum_w;
  logic signed [SW-1:0] diff_w;
  logic signed [CW-1:0] c;
  logic                 past_lim;
  logic                 reach_lim;
  logic                 reach_e2;
  spsc_pkg::res_t       res_data;

  assign accept    = seg.valid && buf_ready;
  assign seg.ready = buf_ready;

  // up and right grow the coordinate, left and down shrink it
  assign outward_pos = (heading == spsc_pkg::HEAD_UP) || (heading == spsc_pkg::HEAD_RIGHT);

  always_comb begin
    if ((heading == spsc_pkg::HEAD_UP) || (heading == spsc_pkg::HEAD_DOWN)) begin
      pos_w = SW'(pos_y);
    end else begin
      pos_w = SW'(pos_x);
    end
  end

  assign dist_w = signed'({{(SW-DIST_WIDTH){1'b0}}, seg.distance});
  assign sum_w  = pos_w + dist_w;
  assign diff_w = pos_w - dist_w;

  always_comb begin
    if (outward_pos) begin
      c = (sum_w > CMAX) ? CMAX[CW-1:0] : sum_w[CW-1:0];
    end else begin
      c = (diff_w < CMIN) ? CMIN[CW-1:0] : diff_w[CW-1:0];
    end
  end

  assign past_lim  = outward_pos ? (c > lim[0]) : (c < lim[0]);
  assign reach_lim = outward_pos ? (c >= lim[0]) : (c <= lim[0]);
  assign reach_e2  = outward_pos ? (c >= elim[2]) : (c <= elim[2]);

  always_comb begin
    pos_x_next     = pos_x;
    pos_y_next     = pos_y;
    lim_upd        = lim;
    elim_upd       = elim;
    shrinking_next = shrinking;
    crossed_next   = crossed_seen;
    if ((heading == spsc_pkg::HEAD_UP) || (heading == spsc_pkg::HEAD_DOWN)) begin
      pos_y_next = c;
    end else begin
      pos_x_next = c;
    end
    if (step_count < spsc_pkg::STEP_FREE) begin
      elim_upd[0] = lim[0];
      lim_upd[0]  = c;
    end else if (shrinking) begin
      if (reach_lim) begin
        crossed_next = 1'b1;
      end else begin
        lim_upd[0] = c;
      end
    end else begin
      elim_upd[0] = lim[0];
      lim_upd[0]  = c;
      if (!past_lim) begin
        // inward spiral starts; the next limit may fall back to the older line
        if (reach_e2) begin
          lim_upd[1] = elim[3];
        end
        shrinking_next = 1'b1;
      end
    end
  end

  assign res_data.crossed  = crossed_seen ? 1'b1 : crossed_next;
  assign res_data.path_end = seg.last;

  always_ff @(posedge clk) begin
    if (rst || (accept && seg.last)) begin
      pos_x        <= '0;
      pos_y        <= '0;
      shrinking    <= 1'b0;
      step_count   <= '0;
      heading      <= spsc_pkg::HEAD_UP;
      crossed_seen <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        lim[k]  <= '0;
        elim[k] <= '0;
      end
    end else if (accept && !crossed_seen) begin
      pos_x        <= pos_x_next;
      pos_y        <= pos_y_next;
      shrinking    <= shrinking_next;
      crossed_seen <= crossed_next;
      heading      <= spsc_pkg::heading_t'(heading + 2'd1);
      if (step_count < spsc_pkg::STEP_SAT) begin
        step_count <= step_count + 3'd1;
      end
      // rotate so that entry 0 follows the new heading
      for (int k = 0; k < 4; k++) begin
        lim[k]  <= lim_upd[(k + 1) % 4];
        elim[k] <= elim_upd[(k + 1) % 4];
      end
    end
  end

  spsc_pkg::res_t out_data;

  spsc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seg.valid),
    .in_ready  (buf_ready),
    .in_data   (res_data),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (out_data)
  );

  assign res.crossed  = out_data.crossed;
  assign res.path_end = out_data.path_end;

endmodule

// ----- rtl/spsc_out_buf.sv -----
module spsc_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  spsc_pkg::res_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output spsc_pkg::res_t    out_data
);

  logic           main_valid;
  logic           skid_valid;
  spsc_pkg::res_t main_data;
  spsc_pkg::res_t skid_data;

  logic load_main;
  logic load_skid;
  logic move_skid;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // main register drains into the receiver, skid holds one transfer during a stall
  assign move_skid = main_valid && out_ready && skid_valid;
  assign load_main = in_valid && !skid_valid && (!main_valid || out_ready);
  assign load_skid = in_valid && !skid_valid && main_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (move_skid) begin
        skid_valid <= 1'b0;
      end else if (load_main) begin
        main_valid <= 1'b1;
      end else if (main_valid && out_ready) begin
        main_valid <= 1'b0;
      end
      if (load_skid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move_skid) begin
      main_data <= skid_data;
    end else if (load_main) begin
      main_data <= in_data;
    end
    if (load_skid) begin
      skid_data <= in_data;
    end
  end

endmodule
